### rtl/sliding_window_rate_limiter_unit_defines.svh
// Assertion macros used by the rate limiter back end.
`ifndef SLIDING_WINDOW_RATE_LIMITER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_RATE_LIMITER_UNIT_DEFINES_SVH

// Checked property, quiet while reset is high.
`define SWRL_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked property, also checked during reset.
`define SWRL_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/swrl_pkg.sv
// Package: types and constants of the sliding-window rate limiter.
`default_nettype none
package swrl_pkg;

   localparam int NUM_KEYS   = 4;
   localparam int LOG_DEPTH  = 16;
   localparam int WAIT_DEPTH = 8;
   localparam int TIME_BITS  = 32;

   localparam int KEY_SLOTS  = 4;
   localparam int KEY_W      = 2;
   localparam int ID_W       = 8;
   localparam int NOW_W      = 32;
   localparam int MAXREQ_W   = 5;
   localparam int WINDOW_W   = 32;
   localparam int TOTAL_W    = 32;

   localparam int HEAD_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LOG_DEPTH + 1);
   localparam int WHEAD_W    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int WCNT_W     = $clog2(WAIT_DEPTH + 1);
   localparam int STAMP_AW   = (NUM_KEYS * LOG_DEPTH > 1) ? $clog2(NUM_KEYS * LOG_DEPTH) : 1;
   localparam int WAIT_AW    = (NUM_KEYS * WAIT_DEPTH > 1) ? $clog2(NUM_KEYS * WAIT_DEPTH) : 1;
   localparam int KIDX_W     = $clog2(NUM_KEYS + 1);

   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;
   localparam int REG_IDX_W  = 3;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_BASE = 3'd4;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_PAUSE   = 2'd1,
      OP_RESUME  = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_GRANTED = 3'd0,
      ST_QUEUED  = 3'd1,
      ST_DROPPED = 3'd2,
      ST_RESUMED = 3'd3,
      ST_COUNT   = 3'd4,
      ST_DONE    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAN_RD,
      S_CLEAN_CMP,
      S_DECIDE,
      S_REPLY,
      S_RES_CHK,
      S_RES_EMIT
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic               key_ok;
      logic [ID_W-1:0]    id;
      logic [NOW_W-1:0]   now;
   } cmd_type;

   typedef struct packed {
      logic [KEY_SLOTS-1:0][MAXREQ_W-1:0] max_req;
      logic [KEY_SLOTS-1:0][WINDOW_W-1:0] window;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic [KEY_W-1:0]   key;
      logic [ID_W-1:0]    requester;
      logic [TOTAL_W-1:0] total;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/sliding_window_rate_limiter_unit.sv
// Top level: per-key sliding-window rate limiter with APB-style register port.
//
// Sliding-window-log rate limiter for four keys. Each acquire transaction
// first drops the key's logged stamps older than its window, then is granted
// and logged, or queued as a waiter (or dropped when the waiter queue is
// full) and counted as rejected. Pause holds all grants; resume releases
// waiters key by key, one result per waiter, then a final done result. The
// front end takes request transactions into a two-entry queue, so the next
// request is taken while the back end works and while a result waits in the
// output register. Cost per transaction is set by the single read port of
// the stamp log memory and the one-result-per-cycle output register (while
// the receiver is ready): an acquire reads and compares stamps oldest first,
// dropping each expired one, then decides; a resume checks each key in turn,
// reading then emitting each waiter it releases, and ends on done. Stamp
// and waiter memories need no clearing pass: only entries inside a key's
// count are read. Register map (32-bit, byte address 4*i): max_requests_0..3
// at 0x00..0x0C, window_ticks_0..3 at 0x10..0x1C. Write registers only while
// the block is idle.
`default_nettype none
module sliding_window_rate_limiter_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [swrl_pkg::KEY_W-1:0]    req_key,
   input  wire logic [swrl_pkg::ID_W-1:0]     req_requester_id,
   input  wire logic [swrl_pkg::NOW_W-1:0]    req_now,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [swrl_pkg::KEY_W-1:0]         rsp_out_key,
   output logic [swrl_pkg::ID_W-1:0]          rsp_out_requester,
   output logic [swrl_pkg::TOTAL_W-1:0]       rsp_rejected_total,
   output logic                               rsp_last,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [swrl_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [swrl_pkg::CSR_DW-1:0]   pwdata,
   output logic [swrl_pkg::CSR_DW-1:0]        prdata,
   output logic                               pready
);
   import swrl_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic [1:0]            reg_slot;
   logic                  csr_write;
   logic                  cmd_valid;
   cmd_type               cmd;
   logic                  cmd_pop;
   rsp_type               rsp;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_AW-1:2];
   assign reg_slot  = reg_idx[1:0];
   assign csr_write = psel && penable && pwrite && pready;

   // Decode the register write: low half holds limits, high half windows.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         if (reg_idx < REG_WINDOW_BASE) begin
            cfg_in.max_req[reg_slot] = pwdata[MAXREQ_W-1:0];
         end else begin
            cfg_in.window[reg_slot] = pwdata[WINDOW_W-1:0];
         end
      end
   end

   // Read back the addressed register.
   always_comb begin
      if (reg_idx < REG_WINDOW_BASE) begin
         prdata = CSR_DW'(cfg_ff.max_req[reg_slot]);
      end else begin
         prdata = CSR_DW'(cfg_ff.window[reg_slot]);
      end
   end

   // Reset values: sixteen requests per window of one tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_SLOTS; k++) begin
            cfg_ff.max_req[k] <= MAXREQ_W'(16);
            cfg_ff.window[k]  <= WINDOW_W'(1);
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swrl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_key          (req_key),
      .req_requester_id (req_requester_id),
      .req_now          (req_now),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   swrl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_ready (rsp_ready)
   );

   // Unpack the result transaction onto its ports.
   assign rsp_status         = rsp.status;
   assign rsp_out_key        = rsp.key;
   assign rsp_out_requester  = rsp.requester;
   assign rsp_rejected_total = rsp.total;
   assign rsp_last           = rsp.last;
endmodule
`default_nettype wire

### rtl/swrl_front.sv
// Front end: accept request transactions, classify them, queue them for the back end.
`default_nettype none
module swrl_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_opcode,
   input  wire logic [swrl_pkg::KEY_W-1:0] req_key,
   input  wire logic [swrl_pkg::ID_W-1:0]  req_requester_id,
   input  wire logic [swrl_pkg::NOW_W-1:0] req_now,
   output logic                            cmd_valid,
   output swrl_pkg::cmd_type               cmd,
   input  wire logic                       cmd_pop
);
   import swrl_pkg::*;

   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    new_cmd;
   logic       push;

   always_comb begin
      new_cmd.op     = op_type'(req_opcode);
      new_cmd.key    = req_key;
      new_cmd.key_ok = ({1'b0, req_key} < (KEY_W + 1)'(NUM_KEYS));
      new_cmd.id     = req_requester_id;
      new_cmd.now    = req_now;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_cmd;
      end
   end
endmodule
`default_nettype wire

### rtl/swrl_back.sv
// Back end: per-key stamp log, waiter queues, counters and the result register.
`default_nettype none
`include "sliding_window_rate_limiter_unit_defines.svh"
module swrl_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire swrl_pkg::cfg_type cfg,
   input  wire logic              cmd_valid,
   input  wire swrl_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   output swrl_pkg::rsp_type      rsp,
   input  wire logic              rsp_ready
);
   import swrl_pkg::*;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [KIDX_W-1:0]        kidx_ff, kidx_in;
   logic                     paused_ff, paused_in;
   logic [HEAD_W-1:0]        st_head_ff [NUM_KEYS];
   logic [HEAD_W-1:0]        st_head_in [NUM_KEYS];
   logic [CNT_W-1:0]         st_cnt_ff  [NUM_KEYS];
   logic [CNT_W-1:0]         st_cnt_in  [NUM_KEYS];
   logic [WHEAD_W-1:0]       wt_head_ff [NUM_KEYS];
   logic [WHEAD_W-1:0]       wt_head_in [NUM_KEYS];
   logic [WCNT_W-1:0]        wt_cnt_ff  [NUM_KEYS];
   logic [WCNT_W-1:0]        wt_cnt_in  [NUM_KEYS];
   logic [TOTAL_W-1:0]       rej_ff     [NUM_KEYS];
   logic [TOTAL_W-1:0]       rej_in     [NUM_KEYS];
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [TIME_BITS-1:0]     stamp_mem [NUM_KEYS * LOG_DEPTH];
   logic [TIME_BITS-1:0]     stamp_rd_ff;
   logic [ID_W-1:0]          wait_mem [NUM_KEYS * WAIT_DEPTH];
   logic [ID_W-1:0]          wait_rd_ff;

   logic                     st_we, st_re, wt_we, wt_re;
   logic [STAMP_AW-1:0]      st_waddr, st_raddr;
   logic [WAIT_AW-1:0]       wt_waddr, wt_raddr;

   logic [KEY_W-1:0]         cur_key;
   logic                     resuming;
   logic [CNT_W-1:0]         lim;
   logic [CNT_W-1:0]         cnt;
   logic [HEAD_W-1:0]        head;
   logic [WCNT_W-1:0]        wcnt;
   logic [WHEAD_W-1:0]       whead;
   logic [TOTAL_W-1:0]       rej;
   logic [TOTAL_W-1:0]       rej_sat;
   logic [CNT_W:0]           st_sum;
   logic [HEAD_W-1:0]        st_slot;
   logic [WCNT_W:0]          wt_sum;
   logic [WHEAD_W-1:0]       wt_slot;
   logic [HEAD_W-1:0]        head_next;
   logic [WHEAD_W-1:0]       whead_next;
   logic [STAMP_AW-1:0]      st_base;
   logic [WAIT_AW-1:0]       wt_base;
   logic [TIME_BITS-1:0]     now_t;
   logic [TIME_BITS-1:0]     age;
   logic                     out_free;
   logic                     emit;

   assign resuming = (state_ff == S_RES_CHK) || (state_ff == S_RES_EMIT);
   assign cur_key  = resuming ? kidx_ff[KEY_W-1:0] : cmd_ff.key;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign now_t    = TIME_BITS'(cmd_ff.now);

   always_comb begin
      cnt   = st_cnt_ff[cur_key];
      head  = st_head_ff[cur_key];
      wcnt  = wt_cnt_ff[cur_key];
      whead = wt_head_ff[cur_key];
      rej   = rej_ff[cur_key];
      lim   = (32'(cfg.max_req[cur_key]) > LOG_DEPTH) ? CNT_W'(LOG_DEPTH)
                                                      : CNT_W'(cfg.max_req[cur_key]);
      rej_sat = (rej == '1) ? rej : rej + 1'b1;
      st_sum  = (CNT_W + 1)'(head) + (CNT_W + 1)'(cnt);
      st_slot = (32'(st_sum) >= LOG_DEPTH) ? HEAD_W'(32'(st_sum) - LOG_DEPTH)
                                           : HEAD_W'(st_sum);
      wt_sum  = (WCNT_W + 1)'(whead) + (WCNT_W + 1)'(wcnt);
      wt_slot = (32'(wt_sum) >= WAIT_DEPTH) ? WHEAD_W'(32'(wt_sum) - WAIT_DEPTH)
                                            : WHEAD_W'(wt_sum);
      head_next  = (head == HEAD_W'(LOG_DEPTH - 1)) ? '0 : head + 1'b1;
      whead_next = (whead == WHEAD_W'(WAIT_DEPTH - 1)) ? '0 : whead + 1'b1;
      st_base = STAMP_AW'(32'(cur_key) * LOG_DEPTH);
      wt_base = WAIT_AW'(32'(cur_key) * WAIT_DEPTH);
      age     = now_t - stamp_rd_ff;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      kidx_in   = kidx_ff;
      paused_in = paused_ff;
      st_head_in = st_head_ff;
      st_cnt_in  = st_cnt_ff;
      wt_head_in = wt_head_ff;
      wt_cnt_in  = wt_cnt_ff;
      rej_in     = rej_ff;
      rsp_in     = rsp_ff;
      emit       = 1'b0;
      cmd_pop    = 1'b0;
      st_we      = 1'b0;
      st_re      = 1'b0;
      wt_we      = 1'b0;
      wt_re      = 1'b0;
      st_waddr   = st_base + STAMP_AW'(st_slot);
      st_raddr   = st_base + STAMP_AW'(head);
      wt_waddr   = wt_base + WAIT_AW'(wt_slot);
      wt_raddr   = wt_base + WAIT_AW'(whead);

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               unique case (cmd.op)
                  OP_PAUSE: begin
                     paused_in = 1'b1;
                     emit      = 1'b1;
                     rsp_in    = '{ST_DONE, '0, '0, '0, 1'b1};
                  end
                  OP_RESUME: begin
                     paused_in = 1'b0;
                     kidx_in   = '0;
                     state_in  = S_RES_CHK;
                  end
                  OP_ACQUIRE: state_in = cmd.key_ok ? S_CLEAN_RD : S_REPLY;
                  OP_READ:    state_in = S_REPLY;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAN_RD: begin
            if (cnt == '0) begin
               state_in = S_DECIDE;
            end else begin
               st_re    = 1'b1;
               state_in = S_CLEAN_CMP;
            end
         end
         S_CLEAN_CMP: begin
            if (64'(age) > 64'(cfg.window[cur_key])) begin
               st_head_in[cur_key] = head_next;
               st_cnt_in[cur_key]  = cnt - 1'b1;
               state_in            = S_CLEAN_RD;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (!paused_ff && cnt < lim) begin
                  st_we              = 1'b1;
                  st_cnt_in[cur_key] = cnt + 1'b1;
                  rsp_in = '{ST_GRANTED, cur_key, cmd_ff.id, rej, 1'b1};
               end else begin
                  rej_in[cur_key] = rej_sat;
                  if (32'(wcnt) < WAIT_DEPTH) begin
                     wt_we              = 1'b1;
                     wt_cnt_in[cur_key] = wcnt + 1'b1;
                     rsp_in = '{ST_QUEUED, cur_key, cmd_ff.id, rej_sat, 1'b1};
                  end else begin
                     rsp_in = '{ST_DROPPED, cur_key, cmd_ff.id, rej_sat, 1'b1};
                  end
               end
            end
         end
         S_REPLY: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               rsp_in   = '{ST_COUNT, cmd_ff.key, '0,
                            cmd_ff.key_ok ? rej : '0, 1'b1};
            end
         end
         S_RES_CHK: begin
            if (32'(kidx_ff) >= NUM_KEYS) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  rsp_in   = '{ST_DONE, '0, '0, '0, 1'b1};
               end
            end else if (wcnt != '0 && cnt < lim) begin
               wt_re    = 1'b1;
               state_in = S_RES_EMIT;
            end else begin
               kidx_in = kidx_ff + 1'b1;
            end
         end
         S_RES_EMIT: begin
            if (out_free) begin
               emit                = 1'b1;
               st_we               = 1'b1;
               st_cnt_in[cur_key]  = cnt + 1'b1;
               wt_head_in[cur_key] = whead_next;
               wt_cnt_in[cur_key]  = wcnt - 1'b1;
               rsp_in   = '{ST_RESUMED, cur_key, wait_rd_ff, rej, 1'b0};
               state_in = S_RES_CHK;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kidx_ff      <= '0;
         paused_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            st_head_ff[k] <= '0;
            st_cnt_ff[k]  <= '0;
            wt_head_ff[k] <= '0;
            wt_cnt_ff[k]  <= '0;
            rej_ff[k]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         kidx_ff      <= kidx_in;
         paused_ff    <= paused_in;
         rsp_valid_ff <= rsp_valid_in;
         st_head_ff   <= st_head_in;
         st_cnt_ff    <= st_cnt_in;
         wt_head_ff   <= wt_head_in;
         wt_cnt_ff    <= wt_cnt_in;
         rej_ff       <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   // Stamp log memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (st_we) begin
         stamp_mem[st_waddr] <= now_t;
      end
      if (st_re) begin
         stamp_rd_ff <= stamp_mem[st_raddr];
      end
   end

   // Waiter memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wt_we) begin
         wait_mem[wt_waddr] <= cmd_ff.id;
      end
      if (wt_re) begin
         wait_rd_ff <= wait_mem[wt_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `SWRL_ASSERT(a_log_bound, st_cnt_ff[cur_key] <= CNT_W'(LOG_DEPTH), "stamp log overflow")
   `SWRL_ASSERT(a_clean_nonempty, state_ff == S_CLEAN_CMP |-> st_cnt_ff[cur_key] != '0, "cleanup compare on empty log")
   `SWRL_ASSERT(a_drain_nonempty, state_ff == S_RES_EMIT |-> wt_cnt_ff[cur_key] != '0, "drain from empty waiter queue")
   `SWRL_ASSERT_ALWAYS(a_done_last, rsp_valid_ff && rsp_ff.status == ST_DONE |-> rsp_ff.last, "done result without last")
endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench for the sliding-window rate limiter: directed table, then random traffic.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import swrl_pkg::*;

   // Register indexes of the configuration port (byte address is 4 * index).
   localparam int REG_MAX0 = 0;
   localparam int REG_WIN0 = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_opcode = '0;
   logic [KEY_W-1:0] req_key = '0;
   logic [ID_W-1:0] req_requester_id = '0;
   logic [NOW_W-1:0] req_now = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [KEY_W-1:0] rsp_out_key;
   logic [ID_W-1:0] rsp_out_requester;
   logic [TOTAL_W-1:0] rsp_rejected_total;
   logic rsp_last;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   sliding_window_rate_limiter_unit dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Give up long after the slowest correct run would have finished.
   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   typedef struct {
      status_type status;
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0] requester;
      logic [TOTAL_W-1:0] total;
      logic last;
   } verdict_type;

   typedef struct {
      op_type op;
      logic [1:0] key;
      logic [7:0] id;
      logic [31:0] now;
      logic typed; // row carries a typed-in expectation
      status_type st;
      logic [31:0] total;
   } row_type;

   // Shadow copy of the limiter state and its registers.
   logic [4:0] lim_max [4];
   logic [31:0] lim_window [4];
   logic lim_paused;
   logic [31:0] stamp_mem [4][16];
   int stamp_hd [4];
   int stamp_cnt [4];
   logic [7:0] waiter_mem [4][8];
   int waiter_hd [4];
   int waiter_cnt [4];
   logic [31:0] reject_cnt [4];

   verdict_type pending_verdicts[$];
   int errors = 0;
   int rsp_gap_max = 0;

   task automatic report(input string what);
      $display("ERROR %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic int limit_for(int k);
      return (lim_max[k] > 16) ? 16 : int'(lim_max[k]);
   endfunction

   function automatic void push_verdict(status_type s, int k, logic [7:0] id,
                                        logic [31:0] tot, logic lst);
      verdict_type v;
      v.status = s; v.key = k[1:0]; v.requester = id; v.total = tot; v.last = lst;
      pending_verdicts.push_back(v);
   endfunction

   function automatic void stamp_push(int k, logic [31:0] t);
      stamp_mem[k][(stamp_hd[k] + stamp_cnt[k]) % 16] = t;
      stamp_cnt[k]++;
   endfunction

   // Work out every result that one accepted transaction causes.
   function automatic void predict_limiter(op_type op, int k, logic [7:0] id,
                                           logic [31:0] t);
      logic [7:0] w;
      case (op)
         OP_PAUSE: begin
            lim_paused = 1'b1;
            push_verdict(ST_DONE, 0, 8'd0, 32'd0, 1'b1);
         end
         OP_RESUME: begin
            lim_paused = 1'b0;
            for (int j = 0; j < NUM_KEYS; j++) begin
               while (waiter_cnt[j] > 0 && stamp_cnt[j] < limit_for(j)) begin
                  w = waiter_mem[j][waiter_hd[j]];
                  waiter_hd[j] = (waiter_hd[j] + 1) % 8;
                  waiter_cnt[j]--;
                  stamp_push(j, t);
                  push_verdict(ST_RESUMED, j, w, reject_cnt[j], 1'b0);
               end
            end
            push_verdict(ST_DONE, 0, 8'd0, 32'd0, 1'b1);
         end
         OP_READ: push_verdict(ST_COUNT, k, 8'd0, reject_cnt[k], 1'b1);
         default: begin
            // Drop expired stamps from the front of the log.
            while (stamp_cnt[k] > 0 &&
                   (t - stamp_mem[k][stamp_hd[k]]) > lim_window[k]) begin
               stamp_hd[k] = (stamp_hd[k] + 1) % 16;
               stamp_cnt[k]--;
            end
            if (!lim_paused && stamp_cnt[k] < limit_for(k)) begin
               stamp_push(k, t);
               push_verdict(ST_GRANTED, k, id, reject_cnt[k], 1'b1);
            end else begin
               if (reject_cnt[k] != 32'hFFFF_FFFF) reject_cnt[k]++;
               if (waiter_cnt[k] < 8) begin
                  waiter_mem[k][(waiter_hd[k] + waiter_cnt[k]) % 8] = id;
                  waiter_cnt[k]++;
                  push_verdict(ST_QUEUED, k, id, reject_cnt[k], 1'b1);
               end else begin
                  push_verdict(ST_DROPPED, k, id, reject_cnt[k], 1'b1);
               end
            end
         end
      endcase
   endfunction

   // Register write: setup cycle, then access cycle; mirror into the shadow copy.
   task automatic csr_write(input int idx, input logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= CSR_AW'(4 * idx); pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx < REG_WIN0) lim_max[idx] = val[4:0];
      else lim_window[idx - REG_WIN0] = val;
   endtask

   // Drop the request, hold off until every expected result has arrived, then settle.
   task automatic drain_wait();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Present one transaction and hold it until accepted; called at a falling edge.
   task automatic present_item(input op_type op, input logic [1:0] k, input logic [7:0] id,
                               input logic [31:0] t, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1; req_opcode <= op; req_key <= k;
      req_requester_id <= id; req_now <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   // Present one transaction, then predict its results once accepted.
   task automatic send_item(input op_type op, input logic [1:0] k, input logic [7:0] id,
                            input logic [31:0] t, input int gap);
      present_item(op, k, id, t, gap);
      predict_limiter(op, int'(k), id, t);
      @(negedge clock);
   endtask

   // Result side: stall at random, compare each accepted result.
   initial begin
      verdict_type v;
      int gap;
      forever begin
         @(negedge clock);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid || reset);
         if (pending_verdicts.size() == 0) begin
            report($sformatf("unexpected result status=%0d", rsp_status));
         end else begin
            v = pending_verdicts[0];
            pending_verdicts.delete(0);
            if (rsp_status !== v.status || rsp_out_key !== v.key ||
                rsp_out_requester !== v.requester || rsp_rejected_total !== v.total ||
                rsp_last !== v.last)
               report($sformatf("got st=%0d k=%0d id=%0d tot=%0d l=%0d, want %0d %0d %0d %0d %0d",
                  rsp_status, rsp_out_key, rsp_out_requester, rsp_rejected_total,
                  rsp_last, v.status, v.key, v.requester, v.total, v.last));
         end
      end
   end

   row_type directed[$];

   function automatic void add_row(op_type op, logic [1:0] k, logic [7:0] id,
                                   logic [31:0] t, logic typed = 1'b0,
                                   status_type st = ST_DONE, logic [31:0] tot = 0);
      row_type r;
      r.op = op; r.key = k; r.id = id; r.now = t; r.typed = typed; r.st = st; r.total = tot;
      directed.push_back(r);
   endfunction

   task automatic random_phase(input int count, input int hot_key);
      op_type op;
      int pick;
      logic [1:0] k;
      logic [31:0] t;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) op = OP_ACQUIRE;
         else if (pick < 80) op = OP_PAUSE;
         else if (pick < 92) op = OP_RESUME;
         else op = OP_READ;
         k = ($urandom_range(0, 1) == 0) ? 2'(hot_key) : 2'($urandom_range(0, 3));
         // Mostly small forward steps in time, with rare wild jumps.
         t = ($urandom_range(0, 15) == 0) ? $urandom : req_now + $urandom_range(0, 6);
         send_item(op, k, 8'($urandom), t,
                   ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 18));
      end
   endtask

   initial begin
      row_type r;
      verdict_type v;
      lim_paused = 1'b0;
      for (int k = 0; k < 4; k++) begin
         lim_max[k] = 5'd16; lim_window[k] = 32'd1;
         stamp_hd[k] = 0; stamp_cnt[k] = 0; waiter_hd[k] = 0; waiter_cnt[k] = 0;
         reject_cnt[k] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      rsp_gap_max = 18;

      // Directed table: typed rows are read straight off the rules.
      add_row(OP_READ, 2'd3, 8'd0, 32'd0, 1'b1, ST_COUNT, 32'd0);
      add_row(OP_ACQUIRE, 2'd0, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_GRANTED, 32'd0);
      add_row(OP_ACQUIRE, 2'd0, 8'h00, 32'd0);            // wrapped age, still in window
      add_row(OP_ACQUIRE, 2'd1, 8'hA5, 32'h0000_0000);
      add_row(OP_PAUSE, 2'd0, 8'd0, 32'd5, 1'b1, ST_DONE, 32'd0);
      add_row(OP_ACQUIRE, 2'd2, 8'h11, 32'd6, 1'b1, ST_QUEUED, 32'd1);
      for (int i = 0; i < 8; i++) add_row(OP_ACQUIRE, 2'd3, 8'(i + 8'h30), 32'd7);
      add_row(OP_ACQUIRE, 2'd3, 8'h5A, 32'd8, 1'b1, ST_DROPPED, 32'd9);  // queue full
      add_row(OP_READ, 2'd3, 8'd0, 32'd8, 1'b1, ST_COUNT, 32'd9);
      add_row(OP_RESUME, 2'd0, 8'd0, 32'h8000_0000);       // drain all waiters
      add_row(OP_READ, 2'd2, 8'd0, 32'd9);
      foreach (directed[i]) begin
         r = directed[i];
         if (r.typed) begin
            // Compare the table's value against the predictor, then send the row.
            predict_limiter(r.op, int'(r.key), r.id, r.now);
            v = pending_verdicts[$];
            if (v.status !== r.st || v.total !== r.total)
               report($sformatf("directed row %0d predicts st=%0d", i, v.status));
            present_item(r.op, r.key, r.id, r.now, $urandom_range(0, 18));
            @(negedge clock);
         end else begin
            send_item(r.op, r.key, r.id, r.now, $urandom_range(0, 18));
         end
      end
      drain_wait();

      // Limit of zero on key 0, mixed limits and windows: key 0 grants nothing, queues or drops every acquire.
      csr_write(REG_MAX0, 32'd0);
      csr_write(REG_MAX0 + 1, 32'd1);
      csr_write(REG_MAX0 + 2, 32'd31);   // above log depth, acts as 16
      csr_write(REG_MAX0 + 3, 32'd2);
      csr_write(REG_WIN0, 32'd0);
      csr_write(REG_WIN0 + 1, 32'd3);
      csr_write(REG_WIN0 + 2, 32'hFFFF_FFFF);
      csr_write(REG_WIN0 + 3, 32'd10);
      random_phase(120, 0);
      drain_wait();

      // Moderate limits, short windows: frequent expiry. No stalls on the result side.
      rsp_gap_max = 0;
      for (int k = 0; k < 4; k++) csr_write(REG_MAX0 + k, 32'($urandom_range(1, 4)));
      for (int k = 0; k < 4; k++) csr_write(REG_WIN0 + k, 32'($urandom_range(2, 12)));
      random_phase(120, 1);
      drain_wait();

      // Full limits, long windows: log fills to its depth.
      rsp_gap_max = 18;
      for (int k = 0; k < 4; k++) csr_write(REG_MAX0 + k, 32'd16);
      for (int k = 0; k < 4; k++) csr_write(REG_WIN0 + k, 32'($urandom_range(20, 200)));
      random_phase(120, 2);

      drain_wait();
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
